@@ hw/rtl/mlfq_pkg.sv @@
// Shared constants, types and helpers of the scheduler fixed-point unit.
package mlfq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int DIV_STEPS = 47;

	localparam logic [10:0] MAX_THREADS = 11'd1024;
	localparam logic signed [31:0] LOAD_COEF = 32'sd16110;
	localparam logic [8:0] LOAD_STEP = 9'd273;
	localparam logic signed [31:0] REPORT_SCALE = 32'sd100;
	localparam logic [7:0] PRI_MAX_RESET = 8'd63;
	localparam logic [7:0] PRI_MIN_RESET = 8'd0;

	localparam logic [2:0] MODE_PRIO = 3'd0;
	localparam logic [2:0] MODE_DECAY = 3'd1;
	localparam logic [2:0] MODE_INC = 3'd2;
	localparam logic [2:0] MODE_LOAD = 3'd3;
	localparam logic [2:0] MODE_LOAD_RPT = 3'd4;
	localparam logic [2:0] MODE_RECENT_RPT = 3'd5;

	localparam logic REG_PRI_MAX = 1'b0;
	localparam logic REG_PRI_MIN = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_DIV,
		S_MUL,
		S_SCL,
		S_FIN
	} state_t;

	typedef struct packed {
		logic cap;
		logic div_start;
		logic mul_en;
		logic scl_en;
		logic fin_en;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic need_mul;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/mlfq_div.sv @@
// Serial restoring divider for the recent cpu decay coefficient 2L*f/(2L+f).
module mlfq_div import mlfq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] load,
	output logic               done,
	output logic signed [31:0] coef
);

	logic signed [46:0] num;
	logic signed [33:0] den;
	logic [46:0] num_mag;
	logic [32:0] den_mag;
	logic [33:0] trial;
	logic [33:0] diff;
	logic        ge;
	logic [32:0] rem_q;
	logic [46:0] quo_q;
	logic [32:0] dmag_q;
	logic        neg_q;
	logic        zero_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        cvt_q;
	logic        done_q;
	logic signed [31:0] coef_q;
	logic signed [31:0] coef_d;
	logic [46:0] quo_neg;

	assign num = {load, 15'b0};
	assign den = {load[31], load, 1'b0} + 34'sd16384;
	assign num_mag = load[31] ? 47'(-num) : 47'(num);
	assign den_mag = den[33] ? 33'((-den) >>> 0) : den[32:0];

	assign trial = {rem_q, quo_q[46]};
	assign ge = trial >= {1'b0, dmag_q};
	assign diff = trial - {1'b0, dmag_q};
	assign quo_neg = -quo_q;

	always_comb begin
		if (zero_q) begin
			coef_d = 32'sd0;
		end else if (!neg_q && quo_q > 47'd2147483647) begin
			coef_d = 32'sh7FFF_FFFF;
		end else if (neg_q && quo_q > 47'd2147483648) begin
			coef_d = 32'sh8000_0000;
		end else if (neg_q) begin
			coef_d = quo_neg[31:0];
		end else begin
			coef_d = quo_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cvt_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					cvt_q <= 1'b1;
				end
			end else if (cvt_q) begin
				cvt_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			dmag_q <= den_mag;
			neg_q <= load[31] ^ den[33];
			zero_q <= (den == 34'sd0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[32:0] : trial[32:0];
			quo_q <= {quo_q[45:0], ge};
		end
		if (cvt_q) begin
			coef_q <= coef_d;
		end
	end

	assign done = done_q;
	assign coef = coef_q;

endmodule

@@ hw/rtl/mlfq_dp.sv @@
// Datapath: operand capture, divider, multiplier, scaling, result and load average.
module mlfq_dp import mlfq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	output dp_stat_t           stat,
	input  logic [2:0]         mode,
	input  logic signed [31:0] recent_cpu_in,
	input  logic signed [5:0]  nice,
	input  logic [10:0]        ready_count,
	input  logic               is_idle,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         priority_out,
	output logic signed [31:0] recent_cpu_out,
	output logic signed [31:0] report_value,
	output logic signed [31:0] load_avg_out
);

	logic [7:0]         pri_max_q;
	logic [7:0]         pri_min_q;
	logic signed [31:0] load_q;
	logic [2:0]         mode_q;
	logic signed [31:0] recent_q;
	logic signed [5:0]  nice_q;
	logic [10:0]        n_q;
	logic               idle_q;
	logic [10:0]        ready_sat;

	logic               div_done;
	logic signed [31:0] coef;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod;
	logic signed [32:0] q4_sum;
	logic signed [63:0] prod_d;
	logic signed [63:0] prod_q;

	logic               round_mode;
	logic [13:0]        bias;
	logic signed [63:0] bias_sum;
	logic signed [49:0] scl_q;

	logic signed [50:0] term;
	logic signed [50:0] fin_sum;
	logic signed [31:0] fin_sat;
	logic signed [32:0] inc_sum;
	logic signed [19:0] prio_p;
	logic signed [19:0] prio_c;
	logic [7:0]         prio_cl;
	logic [7:0]         prio_d;
	logic signed [31:0] rc_d;
	logic signed [31:0] rep_d;
	logic signed [31:0] load_d;

	logic               out_valid_q;
	logic [7:0]         prio_q;
	logic signed [31:0] rc_q;
	logic signed [31:0] rep_q;
	logic signed [31:0] load_out_q;

	mlfq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.load   (load_q),
		.done   (div_done),
		.coef   (coef)
	);

	assign ready_sat = (ready_count > MAX_THREADS) ? MAX_THREADS : ready_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pri_max_q <= PRI_MAX_RESET;
			pri_min_q <= PRI_MIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRI_MAX: pri_max_q <= cfg_data;
				REG_PRI_MIN: pri_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q <= mode;
			recent_q <= recent_cpu_in;
			nice_q <= nice;
			n_q <= ready_sat + {10'b0, ~is_idle};
			idle_q <= is_idle;
		end
	end

	assign stat.need_div = (mode_q == MODE_DECAY) && !idle_q;
	assign stat.need_mul = ((mode_q == MODE_PRIO || mode_q == MODE_DECAY) && !idle_q)
		|| mode_q == MODE_LOAD || mode_q == MODE_LOAD_RPT || mode_q == MODE_RECENT_RPT;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	// multiply, or truncate recent/4 toward zero for the priority
	always_comb begin
		case (mode_q)
			MODE_DECAY: begin
				mul_a = recent_q;
				mul_b = coef;
			end
			MODE_LOAD: begin
				mul_a = load_q;
				mul_b = LOAD_COEF;
			end
			MODE_RECENT_RPT: begin
				mul_a = recent_q;
				mul_b = REPORT_SCALE;
			end
			default: begin
				mul_a = load_q;
				mul_b = REPORT_SCALE;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign q4_sum = {recent_q[31], recent_q} + {31'b0, recent_q[31], recent_q[31]};
	assign prod_d = (mode_q == MODE_PRIO) ? 64'($signed(q4_sum[32:2])) : prod;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
	end

	// divide by f: round half away from zero for reports and priority, else truncate
	assign round_mode = (mode_q == MODE_PRIO) || (mode_q == MODE_LOAD_RPT)
		|| (mode_q == MODE_RECENT_RPT);

	always_comb begin
		if (round_mode) begin
			bias = prod_q[63] ? 14'd8191 : 14'd8192;
		end else begin
			bias = prod_q[63] ? 14'd16383 : 14'd0;
		end
	end

	assign bias_sum = prod_q + $signed({50'b0, bias});

	always_ff @(posedge clk) begin
		if (cmd.scl_en) begin
			scl_q <= bias_sum[63:FRAC_BITS];
		end
	end

	always_comb begin
		case (mode_q)
			MODE_DECAY: term = {{31{nice_q[5]}}, nice_q, 14'b0};
			MODE_LOAD:  term = $signed(51'(n_q) * 51'(LOAD_STEP));
			default:    term = 51'sd0;
		endcase
	end

	assign fin_sum = {scl_q[49], scl_q} + term;
	assign fin_sat = sat32(64'(fin_sum));
	assign inc_sum = {recent_q[31], recent_q} + 33'sd16384;

	assign prio_p = $signed({12'b0, pri_max_q}) - $signed(scl_q[19:0])
		- $signed({{13{nice_q[5]}}, nice_q, 1'b0});

	always_comb begin
		prio_c = (prio_p > $signed({12'b0, pri_max_q})) ? $signed({12'b0, pri_max_q}) : prio_p;
		if (prio_c < $signed({12'b0, pri_min_q})) begin
			prio_cl = pri_min_q;
		end else begin
			prio_cl = prio_c[7:0];
		end
	end

	always_comb begin
		prio_d = 8'd0;
		rc_d = 32'sd0;
		rep_d = 32'sd0;
		load_d = load_q;
		case (mode_q)
			MODE_PRIO: prio_d = idle_q ? pri_min_q : prio_cl;
			MODE_DECAY: rc_d = idle_q ? recent_q : fin_sat;
			MODE_INC: rc_d = idle_q ? recent_q : sat32(64'(inc_sum));
			MODE_LOAD: load_d = fin_sat;
			MODE_LOAD_RPT, MODE_RECENT_RPT: rep_d = fin_sat;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 32'sd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin_en) begin
				load_q <= load_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_en) begin
			prio_q <= prio_d;
			rc_q <= rc_d;
			rep_q <= rep_d;
			load_out_q <= load_d;
		end
	end

	assign out_valid = out_valid_q;
	assign priority_out = prio_q;
	assign recent_cpu_out = rc_q;
	assign report_value = rep_q;
	assign load_avg_out = load_out_q;

endmodule

@@ hw/rtl/mlfq_ctrl.sv @@
// Controller state machine sequencing capture, divide, multiply, scale and result.
module mlfq_ctrl import mlfq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (stat.need_div) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else if (stat.need_mul) begin
					state_d = S_MUL;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d = S_SCL;
			end
			S_SCL: begin
				cmd.scl_en = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.fin_en = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/mlfqs_fixed_point_update_top.sv @@
// Top level of the scheduler fixed-point unit: controller, datapath and ports.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | mode, recent_cpu_in, nice, ready_count, is_idle
//  out     | out_valid / out_ready| priority_out, recent_cpu_out, report_value,
//          |                      | load_avg_out
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One item at a time. Decay (mode 1, not idle) runs through the 47-step serial
// divider, then the multiplier and scaler; priority (not idle), load update and
// both reports go through the multiplier and scaler only; modes 0 to 2 with the
// idle flag, increment and the unused modes skip both.
// Reset sets the load average to zero, pri_max to 63 and pri_min to 0.
// A result waits in the output register; the next item is taken meanwhile.
module mlfqs_fixed_point_update_top import mlfq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic signed [31:0] recent_cpu_in,
	input  logic signed [5:0]  nice,
	input  logic [10:0]        ready_count,
	input  logic               is_idle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         priority_out,
	output logic signed [31:0] recent_cpu_out,
	output logic signed [31:0] report_value,
	output logic signed [31:0] load_avg_out,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	mlfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mlfq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.mode           (mode),
		.recent_cpu_in  (recent_cpu_in),
		.nice           (nice),
		.ready_count    (ready_count),
		.is_idle        (is_idle),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.priority_out   (priority_out),
		.recent_cpu_out (recent_cpu_out),
		.report_value   (report_value),
		.load_avg_out   (load_avg_out)
	);

endmodule
